// ----- hdl/static_linked_list_manager_defines.svh -----
// Assertion macros for the linked list manager.
`ifndef STATIC_LINKED_LIST_MANAGER_DEFINES_SVH
`define STATIC_LINKED_LIST_MANAGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sllm_pkg.sv -----
`timescale 1ns / 1ps

package sllm_pkg;

    localparam int POS_W    = 10;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 10;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic                    op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    list_length;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_HEAD,
        S_INS_FRESH,
        S_INS_NEXT,
        S_DEL_START,
        S_WALK,
        S_INS_LINK,
        S_DEL_GONE,
        S_DEL_FREE,
        S_DEL_PUSH,
        S_FIN
    } state_t;

endpackage

// ----- hdl/static_linked_list_manager.sv -----
// Linked list of up to SLOTS-2 data words kept in a slot memory with a free list: slot 0 heads
// the free list, slot SLOTS-1 heads the data list. Each request inserts a value at a one-based
// position or deletes the element at a position and gives one response with a status and the
// new length. The links sit in one memory with a single registered read port, and the walk to
// the predecessor follows one link per cycle, so a request's time grows with its position. A bad
// position is answered without any memory access; a full list once the free-list head is read.
// A new request is taken while the previous response still waits; a response that is still
// waiting holds the next one back. After reset the link memory is initialised by a pass over
// all SLOTS slots during which no request is accepted.
`timescale 1ns / 1ps
`include "static_linked_list_manager_defines.svh"

module static_linked_list_manager #(
    parameter int SLOTS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sllm_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sllm_pkg::rsp_t out_data
);

    localparam int LW  = $clog2(SLOTS);
    localparam int CW  = (LW > sllm_pkg::LEN_W) ? LW : sllm_pkg::LEN_W;
    localparam int CXW = CW + 1;

    localparam logic [LW-1:0] FREE_HEAD = '0;
    localparam logic [LW-1:0] DATA_HEAD = LW'(SLOTS - 1);
    localparam logic [LW-1:0] LAST_FREE = LW'(SLOTS - 2);

    logic [LW-1:0]             link_mem [SLOTS];
    logic [sllm_pkg::VAL_W-1:0] data_mem [SLOTS];

    sllm_pkg::state_t state_reg, state_next;

    logic [LW-1:0]                 clr_reg, clr_next;
    logic [LW-1:0]                 cur_reg, cur_next;
    logic [LW-1:0]                 fresh_reg, fresh_next;
    logic [sllm_pkg::POS_W-1:0]    steps_reg, steps_next;
    logic                          op_reg, op_next;
    logic [sllm_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [sllm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          out_valid_reg, out_valid_next;
    sllm_pkg::rsp_t                out_reg, out_next;
    logic [LW-1:0]                 rdata_reg;

    logic          rd_en;
    logic [LW-1:0] rd_addr;
    logic          wr_en;
    logic [LW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic          dwr_en;
    logic          out_load;
    logic          accept;
    logic          pos_ok;
    logic [CXW-1:0] pos_ext;
    logic [CXW-1:0] cnt_ext;
    logic [LW-1:0]  clr_init;

    assign accept   = in_valid && in_ready;
    assign pos_ext  = CXW'(in_data.position);
    assign cnt_ext  = {1'b0, count_reg};
    assign clr_init = (clr_reg < LAST_FREE) ? clr_reg + LW'(1) : '0;

    always_comb
    begin
        if (in_data.op == sllm_pkg::OP_INSERT)
        begin
            pos_ok = (in_data.position != '0) && (pos_ext <= cnt_ext + CXW'(1));
        end
        else
        begin
            pos_ok = (in_data.position != '0) && (pos_ext <= cnt_ext);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sllm_pkg::S_CLEAR:
            begin
                if (clr_reg == DATA_HEAD)
                begin
                    state_next = sllm_pkg::S_IDLE;
                end
            end
            sllm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!pos_ok)
                    begin
                        state_next = sllm_pkg::S_FIN;
                    end
                    else if (in_data.op == sllm_pkg::OP_INSERT)
                    begin
                        state_next = sllm_pkg::S_INS_HEAD;
                    end
                    else
                    begin
                        state_next = sllm_pkg::S_DEL_START;
                    end
                end
            end
            sllm_pkg::S_INS_HEAD:  state_next = sllm_pkg::S_INS_FRESH;
            sllm_pkg::S_INS_FRESH:
            begin
                state_next = (rdata_reg == '0) ? sllm_pkg::S_FIN : sllm_pkg::S_INS_NEXT;
            end
            sllm_pkg::S_INS_NEXT:  state_next = sllm_pkg::S_WALK;
            sllm_pkg::S_DEL_START: state_next = sllm_pkg::S_WALK;
            sllm_pkg::S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    state_next = sllm_pkg::S_WALK;
                end
                else if (op_reg == sllm_pkg::OP_INSERT)
                begin
                    state_next = sllm_pkg::S_INS_LINK;
                end
                else if (rdata_reg == '0)
                begin
                    state_next = sllm_pkg::S_FIN;
                end
                else
                begin
                    state_next = sllm_pkg::S_DEL_GONE;
                end
            end
            sllm_pkg::S_INS_LINK:  state_next = sllm_pkg::S_FIN;
            sllm_pkg::S_DEL_GONE:  state_next = sllm_pkg::S_DEL_FREE;
            sllm_pkg::S_DEL_FREE:  state_next = sllm_pkg::S_DEL_PUSH;
            sllm_pkg::S_DEL_PUSH:  state_next = sllm_pkg::S_FIN;
            sllm_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    state_next = sllm_pkg::S_IDLE;
                end
            end
            default:               state_next = sllm_pkg::S_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        dwr_en   = 1'b0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            sllm_pkg::S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = clr_init;
            end
            sllm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            sllm_pkg::S_INS_HEAD:
            begin
                rd_en   = 1'b1;
                rd_addr = FREE_HEAD;
            end
            sllm_pkg::S_INS_FRESH:
            begin
                rd_en   = (rdata_reg != '0);
                rd_addr = rdata_reg;
            end
            sllm_pkg::S_INS_NEXT:
            begin
                wr_en   = 1'b1;
                wr_addr = FREE_HEAD;
                wr_data = rdata_reg;
                dwr_en  = 1'b1;
                rd_en   = 1'b1;
                rd_addr = DATA_HEAD;
            end
            sllm_pkg::S_DEL_START:
            begin
                rd_en   = 1'b1;
                rd_addr = DATA_HEAD;
            end
            sllm_pkg::S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rdata_reg;
                end
                else if (op_reg == sllm_pkg::OP_INSERT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = fresh_reg;
                    wr_data = rdata_reg;
                end
                else
                begin
                    rd_en   = (rdata_reg != '0);
                    rd_addr = rdata_reg;
                end
            end
            sllm_pkg::S_INS_LINK:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = fresh_reg;
            end
            sllm_pkg::S_DEL_GONE:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = rdata_reg;
                rd_en   = 1'b1;
                rd_addr = FREE_HEAD;
            end
            sllm_pkg::S_DEL_FREE:
            begin
                wr_en   = 1'b1;
                wr_addr = fresh_reg;
                wr_data = rdata_reg;
            end
            sllm_pkg::S_DEL_PUSH:
            begin
                wr_en   = 1'b1;
                wr_addr = FREE_HEAD;
                wr_data = fresh_reg;
            end
            sllm_pkg::S_FIN:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        fresh_next     = fresh_reg;
        steps_next     = steps_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = status_reg;
            out_next.list_length = count_reg[sllm_pkg::LEN_W-1:0];
        end

        case (state_reg)
            sllm_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + LW'(1);
            end
            sllm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_data.op;
                    val_next    = in_data.value;
                    steps_next  = in_data.position - sllm_pkg::POS_W'(1);
                    status_next = pos_ok ? sllm_pkg::ST_DONE : sllm_pkg::ST_BAD_POS;
                end
            end
            sllm_pkg::S_INS_FRESH:
            begin
                fresh_next = rdata_reg;
                if (rdata_reg == '0)
                begin
                    status_next = sllm_pkg::ST_FULL;
                end
            end
            sllm_pkg::S_INS_NEXT,
            sllm_pkg::S_DEL_START:
            begin
                cur_next = DATA_HEAD;
            end
            sllm_pkg::S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    cur_next   = rdata_reg;
                    steps_next = steps_reg - sllm_pkg::POS_W'(1);
                end
                else if (op_reg == sllm_pkg::OP_DELETE)
                begin
                    fresh_next = rdata_reg;
                end
            end
            sllm_pkg::S_INS_LINK:
            begin
                count_next = count_reg + CW'(1);
            end
            sllm_pkg::S_DEL_PUSH:
            begin
                count_next = count_reg - CW'(1);
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sllm_pkg::S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        fresh_reg  <= fresh_next;
        steps_reg  <= steps_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dwr_en)
        begin
            data_mem[fresh_reg] <= val_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SLLM_ASSERT_NOW(a_walk_chain,
        (state_reg == sllm_pkg::S_WALK) && (steps_reg != '0), rdata_reg != '0,
        "data chain ended before the position")
    `SLLM_ASSERT_NOW(a_free_matches_count,
        state_reg == sllm_pkg::S_INS_FRESH,
        (rdata_reg == '0) == (count_reg == CW'(SLOTS - 2)),
        "free list disagrees with element count")
    `SLLM_ASSERT_NEXT(a_insert_count,
        state_reg == sllm_pkg::S_INS_LINK, count_reg == $past(count_reg) + CW'(1),
        "insert did not bump the count")
    `SLLM_ASSERT_NEXT(a_delete_count,
        state_reg == sllm_pkg::S_DEL_PUSH, count_reg == $past(count_reg) - CW'(1),
        "delete did not drop the count")

endmodule

// ----- tb/static_linked_list_manager_tb.sv -----
`timescale 1ns / 1ps

module static_linked_list_manager_tb;

    localparam int N_SLOTS     = 1024;
    localparam int SLOT_W      = $clog2(N_SLOTS);
    localparam int CAPACITY    = N_SLOTS - 2;
    localparam int STALL_LIMIT = 8 * N_SLOTS;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 128;

    typedef logic [SLOT_W-1:0] slot_t;

    localparam slot_t FREE_HEAD = slot_t'(0);
    localparam slot_t DATA_HEAD = slot_t'(N_SLOTS - 1);

    class list_scoreboard;
        slot_t          next_slot [N_SLOTS];
        int unsigned    count;
        sllm_pkg::rsp_t pending [$];
        int             errors;
        int             requests;
        int             inserts;
        int             deletes;
        int             bad_pos;
        int             full_hits;
        int unsigned    max_len;

        function new();
            for (int i = 0; i < N_SLOTS; i++)
                next_slot[i] = '0;
            for (int i = 0; i + 2 < N_SLOTS; i++)
                next_slot[i] = slot_t'(i + 1);
            count = 0;
            errors = 0;
            requests = 0;
            inserts = 0;
            deletes = 0;
            bad_pos = 0;
            full_hits = 0;
            max_len = 0;
        endfunction

        function slot_t walk(int unsigned steps);
            slot_t cur;
            cur = DATA_HEAD;
            for (int unsigned k = 0; k < steps; k++)
                cur = next_slot[cur];
            return cur;
        endfunction

        function void note_request(sllm_pkg::req_t r);
            sllm_pkg::rsp_t exp;
            slot_t          fresh;
            slot_t          pred;
            slot_t          gone;
            exp.status = sllm_pkg::ST_DONE;
            if (r.op == sllm_pkg::OP_INSERT)
            begin
                if (r.position == 0 || r.position > count + 1)
                    exp.status = sllm_pkg::ST_BAD_POS;
                else
                begin
                    fresh = next_slot[FREE_HEAD];
                    if (fresh == FREE_HEAD)
                        exp.status = sllm_pkg::ST_FULL;
                    else
                    begin
                        next_slot[FREE_HEAD] = next_slot[fresh];
                        pred = walk(r.position - 1);
                        next_slot[fresh] = next_slot[pred];
                        next_slot[pred] = fresh;
                        count++;
                        inserts++;
                    end
                end
            end
            else
            begin
                if (r.position == 0 || r.position > count)
                    exp.status = sllm_pkg::ST_BAD_POS;
                else
                begin
                    pred = walk(r.position - 1);
                    gone = next_slot[pred];
                    if (gone != FREE_HEAD)
                    begin
                        next_slot[pred] = next_slot[gone];
                        next_slot[gone] = next_slot[FREE_HEAD];
                        next_slot[FREE_HEAD] = gone;
                        count--;
                        deletes++;
                    end
                end
            end
            exp.list_length = sllm_pkg::LEN_W'(count);
            pending.push_back(exp);
            requests++;
            if (exp.status == sllm_pkg::ST_BAD_POS)
                bad_pos++;
            if (exp.status == sllm_pkg::ST_FULL)
                full_hits++;
            if (count > max_len)
                max_len = count;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(sllm_pkg::rsp_t r);
            sllm_pkg::rsp_t exp;
            if (pending.size() == 0)
                report($sformatf("response with none outstanding: status %0d length %0d",
                                 r.status, r.list_length));
            else
            begin
                exp = pending.pop_front();
                if (r.status !== exp.status)
                    report($sformatf("status %0d, want %0d", r.status, exp.status));
                if (r.list_length !== exp.list_length)
                    report($sformatf("list_length %0d, want %0d",
                                     r.list_length, exp.list_length));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sllm_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sllm_pkg::rsp_t out_data;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    list_scoreboard sb;

    static_linked_list_manager #(
        .SLOTS(N_SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(out_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("static_linked_list_manager test failed");
            $finish;
        end
    end

    // request is noted at the edge it is accepted
    task automatic send_request(input sllm_pkg::req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic send_op(input logic op, input int pos,
                           input logic [sllm_pkg::VAL_W-1:0] val);
        sllm_pkg::req_t r;
        r.op = op;
        r.position = sllm_pkg::POS_W'(pos);
        r.value = val;
        send_request(r);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic sllm_pkg::req_t random_request(int grow_pct);
        sllm_pkg::req_t r;
        int unsigned    len;
        int unsigned    top;
        int             pick;
        len = sb.count;
        r.value = $urandom;
        pick = $urandom_range(99);
        if (len == 0 || len >= CAPACITY)
            r.op = (len == 0) ? sllm_pkg::OP_INSERT : sllm_pkg::OP_DELETE;
        else
            r.op = ($urandom_range(99) < grow_pct) ? sllm_pkg::OP_INSERT
                                                   : sllm_pkg::OP_DELETE;
        if (pick < 15)
            r.op = 1'($urandom_range(1));
        top = (r.op == sllm_pkg::OP_INSERT) ? len + 1 : len;
        if (pick < 5)
            r.position = sllm_pkg::POS_W'(top + 1);
        else if (pick < 8)
            r.position = '0;
        else if (pick < 15)
            r.position = sllm_pkg::POS_W'($urandom_range(1023));
        else
        begin
            case ($urandom_range(3))
                0: r.position = sllm_pkg::POS_W'(1);
                1: r.position = sllm_pkg::POS_W'(top);
                2: r.position = sllm_pkg::POS_W'($urandom_range(top, 1));
                default: r.position = sllm_pkg::POS_W'($urandom_range(top < 16 ? top : 16, 1));
            endcase
        end
        return r;
    endfunction

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, ends, middle, out of range
        send_op(sllm_pkg::OP_DELETE, 1, 32'h0000_0000);
        send_op(sllm_pkg::OP_INSERT, 0, 32'h1234_5678);
        send_op(sllm_pkg::OP_INSERT, 2, 32'h1234_5678);
        send_op(sllm_pkg::OP_INSERT, 1, 32'h7FFF_FFFF);
        send_op(sllm_pkg::OP_INSERT, 1, 32'h8000_0000);
        send_op(sllm_pkg::OP_INSERT, 3, 32'h0000_0000);
        send_op(sllm_pkg::OP_INSERT, 2, 32'hFFFF_FFFF);
        send_op(sllm_pkg::OP_INSERT, 1023, 32'hA5A5_A5A5);
        send_op(sllm_pkg::OP_INSERT, 512, 32'h5A5A_5A5A);
        send_op(sllm_pkg::OP_INSERT, 6, 32'h0000_0001);
        send_op(sllm_pkg::OP_DELETE, 0, 32'hFFFF_FFFF);
        send_op(sllm_pkg::OP_DELETE, 5, 32'h0000_0000);
        send_op(sllm_pkg::OP_DELETE, 1023, 32'hFFFF_FFFF);
        send_op(sllm_pkg::OP_DELETE, 4, 32'h0000_0000);
        send_op(sllm_pkg::OP_DELETE, 2, 32'h0000_0000);
        send_op(sllm_pkg::OP_DELETE, 1, 32'h0000_0000);
        send_op(sllm_pkg::OP_INSERT, 2, 32'hDEAD_BEEF);
        send_op(sllm_pkg::OP_DELETE, 2, 32'h0000_0000);
        send_op(sllm_pkg::OP_DELETE, 1, 32'h0000_0000);
        send_op(sllm_pkg::OP_DELETE, 1, 32'h0000_0000);
        in_valid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 71;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 71;
                end
                default:
                begin
                    idle_pct = 38;
                    stall_pct = 38;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(phase == 3 ? 45 : 62));
            in_valid <= 1'b0;
            wait_drained();
        end

        // ends and just past them at the length reached
        idle_pct = 0;
        stall_pct = 38;
        send_op(sllm_pkg::OP_INSERT, 1, $urandom);
        send_op(sllm_pkg::OP_INSERT, sb.count + 1, $urandom);
        send_op(sllm_pkg::OP_INSERT, 0, $urandom);
        send_op(sllm_pkg::OP_DELETE, sb.count, $urandom);
        send_op(sllm_pkg::OP_INSERT, sb.count + 1, $urandom);
        send_op(sllm_pkg::OP_INSERT, sb.count, $urandom);
        send_op(sllm_pkg::OP_DELETE, sb.count + 1, $urandom);
        idle_pct = 38;
        for (int n = 0; n < 40; n++)
            send_request(random_request(30));
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Ran %0d requests: %0d inserts, %0d deletes, %0d bad positions, %0d full",
                 sb.requests, sb.inserts, sb.deletes, sb.bad_pos, sb.full_hits);
        $display("Longest list %0d of %0d elements; %0d mismatches",
                 sb.max_len, CAPACITY, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("static_linked_list_manager test passed");
        else
            $display("static_linked_list_manager test failed");
        $finish;
    end
endmodule
